### sv/timestamp_ring_nearest_pick_core_macros.svh
// ----------------------------------------------------------------------------
// Timestamp ring assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_RING_NEAREST_PICK_CORE_MACROS_SVH
`define TIMESTAMP_RING_NEAREST_PICK_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define TRNP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TRNP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/trnp_pkg.sv
// ----------------------------------------------------------------------------
// Timestamp ring package
// Beat types, request codes, controller states and control structs.
// ----------------------------------------------------------------------------
package trnp_pkg;

	localparam int DEPTH  = 64;
	localparam int SLOT_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int TIME_W = 48;

	localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(DEPTH);

	// request codes
	localparam logic [1:0] REQ_PUSH  = 2'd0;
	localparam logic [1:0] REQ_PICK  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [TIME_W-1:0] time_in;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] time_out;
		logic              valid_res;
		logic              clamped;
		logic [TIME_W-1:0] newest_time;
		logic [TIME_W-1:0] oldest_time;
		logic [CNT_W-1:0]  held_count;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_PUSH,
		ST_OLD_RD,
		ST_OLD_CAP,
		ST_PICK,
		ST_SRCH,
		ST_SRCH_CMP,
		ST_PK_DIFF,
		ST_PK_FIN,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic accept;
		logic clear;
		logic push;
		logic pick_eval;
		logic srch_rd;
		logic srch_cmp;
		logic pk_diff;
		logic pk_fin;
		logic rd_old;
		logic cap_old;
		logic load_res;
	} cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       pk_empty;
		logic       pk_edge;
		logic       span_gt1;
		logic       push_wraps;
	} sts_t;

endpackage

### sv/timestamp_ring_nearest_pick_core.sv
// ----------------------------------------------------------------------------
// Timestamp ring nearest pick core
// Ring of strictly increasing frame times with push, nearest pick and clear.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload           beat taken when
//  -------   ---------          -------           ---------------
//  request   start / busy       req   (req_t)     start && !busy
//  result    done (strobe)      res   (res_t)     done, one cycle, no backpressure
//  config    cfg_we             cfg_wdata[6:0]    cfg_we
//
//  After dispatch, clear or unknown requests go straight to the response; a push
//  on a full ring adds a read-back of the new oldest entry. A pick at or beyond
//  the held range needs no search; a pick inside it runs k search probes,
//  at most 6 for 64 entries, then picks the nearer of the two bracketing entries.
//  Each probe uses the single store read port (address, then registered
//  data). busy is high from the beat until the strobe cycle, in which a new
//  request beat may already be taken.
//  Reset clears state to an empty ring of capacity 64; no clearing pass.
//  Results cannot be stalled; the receiver must take each strobe.
//
module timestamp_ring_nearest_pick_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  trnp_pkg::req_t             req,
	output logic                       done,
	output trnp_pkg::res_t             res,
	input  logic                       cfg_we,
	input  logic [trnp_pkg::CNT_W-1:0] cfg_wdata
);
	import trnp_pkg::*;

	// controller to datapath: one-hot-ish step commands
	cmd_t cmd;
	// datapath to controller: request kind and branch conditions
	sts_t sts;

	// sequencer: dispatch, push, pick classification, search loop, response
	trnp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	// store, head/count pointers, search bounds, result register
	trnp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.res       (res)
	);

endmodule

### sv/trnp_ctrl.sv
// ----------------------------------------------------------------------------
// Timestamp ring controller
// Sequences push, pick search and clear; drives busy and the result strobe.
// ----------------------------------------------------------------------------
module trnp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output trnp_pkg::cmd_t cmd,
	input  trnp_pkg::sts_t sts
);
	import trnp_pkg::*;

	state_t state_q;
	state_t state_nx;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= cmd.load_res;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_nx = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				case (sts.req_type)
					REQ_PUSH: state_nx = ST_PUSH;
					REQ_PICK: state_nx = ST_PICK;
					default:  state_nx = ST_RESP;
				endcase
			end
			ST_PUSH:     state_nx = sts.push_wraps ? ST_OLD_RD : ST_RESP;
			ST_OLD_RD:   state_nx = ST_OLD_CAP;
			ST_OLD_CAP:  state_nx = ST_RESP;
			ST_PICK:     state_nx = (sts.pk_empty || sts.pk_edge) ? ST_RESP : ST_SRCH;
			ST_SRCH:     state_nx = sts.span_gt1 ? ST_SRCH_CMP : ST_PK_DIFF;
			ST_SRCH_CMP: state_nx = ST_SRCH;
			ST_PK_DIFF:  state_nx = ST_PK_FIN;
			ST_PK_FIN:   state_nx = ST_RESP;
			ST_RESP:     state_nx = ST_IDLE;
			default:     state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.accept    = (state_q == ST_IDLE) && start;
		cmd.clear     = (state_q == ST_DISPATCH) && (sts.req_type == REQ_CLEAR);
		cmd.push      = (state_q == ST_PUSH);
		cmd.rd_old    = (state_q == ST_OLD_RD);
		cmd.cap_old   = (state_q == ST_OLD_CAP);
		cmd.pick_eval = (state_q == ST_PICK);
		cmd.srch_rd   = (state_q == ST_SRCH) && sts.span_gt1;
		cmd.srch_cmp  = (state_q == ST_SRCH_CMP);
		cmd.pk_diff   = (state_q == ST_PK_DIFF);
		cmd.pk_fin    = (state_q == ST_PK_FIN);
		cmd.load_res  = (state_q == ST_RESP);
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

### sv/trnp_dp.sv
// ----------------------------------------------------------------------------
// Timestamp ring datapath
// Time store, ring pointers, search bounds and the result register.
// ----------------------------------------------------------------------------
module trnp_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  trnp_pkg::req_t               req,
	input  logic                         cfg_we,
	input  logic [trnp_pkg::CNT_W-1:0]   cfg_wdata,
	input  trnp_pkg::cmd_t               cmd,
	output trnp_pkg::sts_t               sts,
	output trnp_pkg::res_t               res
);
	import trnp_pkg::*;

	// time store, registered read
	logic [TIME_W-1:0] mem [DEPTH];
	logic [TIME_W-1:0] rd_data_q;

	// control state
	logic [CNT_W-1:0]  cap_q;
	logic [SLOT_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;

	// payload
	logic [1:0]        req_q;
	logic [TIME_W-1:0] t_q;
	logic [TIME_W-1:0] newest_q;
	logic [TIME_W-1:0] oldest_q;
	logic [SLOT_W-1:0] lo_q;
	logic [SLOT_W-1:0] hi_q;
	logic [TIME_W-1:0] before_q;
	logic [TIME_W-1:0] after_q;
	logic              gt_q;
	logic [SLOT_W-1:0] slot_q;
	logic [TIME_W-1:0] tout_q;
	logic              valid_q;
	logic              clamped_q;
	res_t              res_q;

	// maps an age (0 = oldest) to a slot: (first + age) mod cap
	function automatic logic [SLOT_W-1:0] age_slot(
		input logic [SLOT_W-1:0] first,
		input logic [SLOT_W-1:0] age,
		input logic [CNT_W-1:0]  cap
	);
		logic [SLOT_W:0] sum;
		sum = {1'b0, first} + {1'b0, age};
		if (sum >= cap) sum = sum - cap;
		return sum[SLOT_W-1:0];
	endfunction

	logic [SLOT_W-1:0] first;
	logic [SLOT_W-1:0] cnt_m1;
	logic              empty_first;
	logic [CNT_W-1:0]  c0;
	logic [SLOT_W-1:0] h0;
	logic [SLOT_W:0]   h_inc;
	logic [SLOT_W-1:0] head_nx;
	logic              wraps;
	logic [CNT_W-1:0]  count_nx;
	logic              le_old;
	logic              ge_new;
	logic [SLOT_W-1:0] span;
	logic [SLOT_W-1:0] mid;
	logic [SLOT_W-1:0] rd_addr;
	logic [CNT_W-1:0]  cap_wr;

	always_comb begin
		first       = (count_q == cap_q) ? head_q : '0;
		cnt_m1      = SLOT_W'(count_q - CNT_W'(1));
		// a push that does not advance past the newest restarts the ring
		empty_first = (count_q != '0) && (t_q <= newest_q);
		c0          = empty_first ? '0 : count_q;
		h0          = empty_first ? '0 : head_q;
		h_inc       = {1'b0, h0} + (SLOT_W+1)'(1);
		head_nx     = (CNT_W'(h_inc) == cap_q) ? '0 : h_inc[SLOT_W-1:0];
		wraps       = (c0 == cap_q);
		count_nx    = wraps ? c0 : c0 + CNT_W'(1);
		le_old      = (t_q <= oldest_q);
		ge_new      = (t_q >= newest_q);
		span        = hi_q - lo_q;
		mid         = lo_q + (span >> 1);
		rd_addr     = cmd.rd_old ? head_q : age_slot(first, mid, cap_q);
		// capacity clamps to 1..DEPTH
		if (cfg_wdata == '0) cap_wr = CNT_W'(1);
		else if (cfg_wdata > CAP_MAX) cap_wr = CAP_MAX;
		else cap_wr = cfg_wdata;
	end

	always_comb begin
		sts.req_type   = req_q;
		sts.pk_empty   = (count_q == '0);
		sts.pk_edge    = le_old || ge_new;
		sts.span_gt1   = (span > SLOT_W'(1));
		sts.push_wraps = wraps;
	end

	always_ff @(posedge clk) begin
		if (cmd.push) mem[h0] <= t_q;
		if (cmd.srch_rd || cmd.rd_old) rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_MAX;
			head_q  <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			cap_q   <= cap_wr;
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.clear) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.push) begin
			head_q  <= head_nx;
			count_q <= count_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q     <= req.req_type;
			t_q       <= req.time_in;
			slot_q    <= '0;
			tout_q    <= '0;
			valid_q   <= 1'b0;
			clamped_q <= 1'b0;
		end
		if (cmd.push) begin
			newest_q <= t_q;
			if (c0 == '0) oldest_q <= t_q;
			slot_q   <= h0;
			tout_q   <= t_q;
			valid_q  <= 1'b1;
		end
		if (cmd.cap_old) oldest_q <= rd_data_q;
		if (cmd.pick_eval && (count_q != '0)) begin
			valid_q <= 1'b1;
			if (le_old) begin
				slot_q    <= first;
				tout_q    <= oldest_q;
				clamped_q <= (t_q < oldest_q);
			end else if (ge_new) begin
				slot_q    <= age_slot(first, cnt_m1, cap_q);
				tout_q    <= newest_q;
				clamped_q <= (t_q > newest_q);
			end else begin
				lo_q     <= '0;
				hi_q     <= cnt_m1;
				before_q <= oldest_q;
				after_q  <= newest_q;
			end
		end
		if (cmd.srch_cmp) begin
			if (rd_data_q <= t_q) begin
				lo_q     <= mid;
				before_q <= rd_data_q;
			end else begin
				hi_q    <= mid;
				after_q <= rd_data_q;
			end
		end
		if (cmd.pk_diff) gt_q <= ((t_q - before_q) > (after_q - t_q));
		if (cmd.pk_fin) begin
			slot_q <= age_slot(first, gt_q ? hi_q : lo_q, cap_q);
			tout_q <= gt_q ? after_q : before_q;
		end
		if (cmd.load_res) begin
			res_q.slot        <= slot_q;
			res_q.time_out    <= tout_q;
			res_q.valid_res   <= valid_q;
			res_q.clamped     <= clamped_q;
			res_q.newest_time <= (count_q != '0) ? newest_q : '0;
			res_q.oldest_time <= (count_q != '0) ? oldest_q : '0;
			res_q.held_count  <= count_q;
		end
	end

	assign res = res_q;

endmodule

### sv/trnp_chk.sv
// ----------------------------------------------------------------------------
// Timestamp ring port checker
// Port-level properties of the core, bound to the top level.
// ----------------------------------------------------------------------------
`include "timestamp_ring_nearest_pick_core_macros.svh"

module trnp_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input trnp_pkg::res_t res
);
	import trnp_pkg::*;

	// an accepted beat raises busy in the next cycle
	`TRNP_ASSERT_NXT(a_accept_busy, start && !busy, busy, "no busy after request beat")

	// the strobe cycle is an idle cycle
	`TRNP_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")

	// strobe lasts one cycle per item
	`TRNP_ASSERT_NXT(a_done_pulse, done, !done, "result strobe held two cycles")

	// a result without a hit carries no slot, time or clamp
	`TRNP_ASSERT_NOW(a_miss_zero, done && !res.valid_res,
		(res.slot == '0) && (res.time_out == '0) && !res.clamped,
		"invalid result with nonzero payload")

	// empty ring reports zero range
	`TRNP_ASSERT_NOW(a_empty_range, done && (res.held_count == '0),
		(res.newest_time == '0) && (res.oldest_time == '0),
		"empty ring with nonzero range")

endmodule

bind timestamp_ring_nearest_pick_core trnp_chk u_trnp_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.res    (res)
);
